/* rtl/sia_pkg.sv */
// Shared types, constants and helpers for the signed integer to ASCII converter.
// No dependencies; every other file of the block but sia_ram uses it.
package sia_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 7;

  localparam logic [BASE_W-1:0] BASE_MIN      = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX      = 6'd36;
  localparam logic [BASE_W-1:0] DECIMAL_LIMIT = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO          = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_LETTER_OFFSET = 7'h37;
  localparam logic [CHAR_W-1:0] CHAR_MINUS         = 7'h2D;

  typedef struct packed {
    logic load;
    logic step;
    logic digit;
    logic sign_out;
    logic fetch;
    logic digit_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic q_zero;
    logic neg;
    logic ndig_zero;
    logic slot_free;
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] dx;
    dx = {1'b0, d};
    return (d < DECIMAL_LIMIT) ? (dx + CHAR_ZERO) : (dx + CHAR_LETTER_OFFSET);
  endfunction

endpackage

/* rtl/sia_if.sv */
// Valid/ready channel interfaces for the integer word and the character word.
// Depends on sia_pkg for field widths.
interface sia_in_if #(
  parameter int VALUE_WIDTH = sia_pkg::VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [sia_pkg::BASE_W-1:0]    base;

  modport source (output valid, output value, output base, input ready);
  modport sink   (input valid, input value, input base, output ready);
endinterface

interface sia_out_if;
  logic                       valid;
  logic                       ready;
  logic [sia_pkg::CHAR_W-1:0] ascii_code;
  logic                       last_char;

  modport source (output valid, output ascii_code, output last_char, input ready);
  modport sink   (input valid, input ascii_code, input last_char, output ready);
endinterface

/* rtl/sia_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sia_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/sia_ctrl.sv */
// Sequencer for conversion: divide, store digit, emit sign and digits.
// Depends on sia_pkg for the command and status structs.
module sia_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sia_pkg::sts_t sts,
  output sia_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_DIGIT,
    ST_SIGN,
    ST_FETCH,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = rst_n;
        cmd.load = in_valid && rst_n;
        if (in_valid && rst_n) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_last) state_nxt = ST_DIGIT;
      end
      ST_DIGIT: begin
        cmd.digit = 1'b1;
        if (sts.q_zero) state_nxt = sts.neg ? ST_SIGN : ST_FETCH;
        else state_nxt = ST_DIV;
      end
      ST_SIGN: begin
        if (sts.slot_free) begin
          cmd.sign_out = 1'b1;
          state_nxt    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.digit_out = 1'b1;
          state_nxt     = sts.ndig_zero ? ST_IDLE : ST_FETCH;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* rtl/sia_dp.sv */
// Datapath: magnitude, bit-serial divider, digit stack and output register.
// Depends on sia_pkg and sia_ram.
module sia_dp #(
  parameter int VALUE_WIDTH = sia_pkg::VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic [sia_pkg::BASE_W-1:0]    in_base,
  input  sia_pkg::cmd_t                 cmd,
  output sia_pkg::sts_t                 sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sia_pkg::CHAR_W-1:0]    out_ascii_code,
  output logic                          out_last_char
);

  localparam int SLOTS = VALUE_WIDTH + 1;
  localparam int AW    = $clog2(SLOTS);
  localparam int CW    = $clog2(VALUE_WIDTH);
  localparam int BW    = sia_pkg::BASE_W;

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BW-1:0]          rem_r, rem_nxt;
  logic [BW-1:0]          base_r;
  logic                   neg_r;
  logic [CW-1:0]          bitcnt_r;
  logic [AW-1:0]          ndig_r;
  logic [BW:0]            rem_t;
  logic [BW-1:0]          rem_sub;
  logic                   ge;
  logic [BW-1:0]          base_clamp;
  logic [BW-1:0]          rd_digit;

  logic                         out_valid_r;
  logic [sia_pkg::CHAR_W-1:0]   out_code_r;
  logic                         out_last_r;

  always_comb begin
    if (in_base < sia_pkg::BASE_MIN) base_clamp = sia_pkg::BASE_MIN;
    else if (in_base > sia_pkg::BASE_MAX) base_clamp = sia_pkg::BASE_MAX;
    else base_clamp = in_base;
  end

  assign rem_t   = {rem_r, mag_r[VALUE_WIDTH-1]};
  assign ge      = rem_t >= {1'b0, base_r};
  assign rem_sub = rem_t[BW-1:0] - base_r;
  assign rem_nxt = ge ? rem_sub : rem_t[BW-1:0];
  assign mag_nxt = {mag_r[VALUE_WIDTH-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg_r    <= in_value[VALUE_WIDTH-1];
      mag_r    <= in_value[VALUE_WIDTH-1] ? (~in_value + 1'b1) : in_value;
      base_r   <= base_clamp;
      rem_r    <= '0;
      bitcnt_r <= '0;
      ndig_r   <= '0;
    end else if (cmd.step) begin
      mag_r    <= mag_nxt;
      rem_r    <= rem_nxt;
      bitcnt_r <= bitcnt_r + 1'b1;
    end else if (cmd.digit) begin
      rem_r    <= '0;
      bitcnt_r <= '0;
      ndig_r   <= ndig_r + 1'b1;
    end else if (cmd.fetch) begin
      ndig_r   <= ndig_r - 1'b1;
    end
  end

  sia_ram #(
    .WIDTH (BW),
    .DEPTH (SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.digit),
    .waddr (ndig_r),
    .wdata (rem_r),
    .re    (cmd.fetch),
    .raddr (ndig_r - 1'b1),
    .rdata (rd_digit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.sign_out || cmd.digit_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sign_out) begin
      out_code_r <= sia_pkg::CHAR_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.digit_out) begin
      out_code_r <= sia_pkg::digit_char(rd_digit);
      out_last_r <= (ndig_r == '0);
    end
  end

  assign sts.div_last  = (bitcnt_r == CW'(VALUE_WIDTH - 1));
  assign sts.q_zero    = (mag_r == '0);
  assign sts.neg       = neg_r;
  assign sts.ndig_zero = (ndig_r == '0);
  assign sts.slot_free = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_ascii_code = out_code_r;
  assign out_last_char  = out_last_r;

endmodule

/* rtl/signed_integer_to_ascii_base_core.sv */
// Top level of the signed integer to ASCII converter: controller plus datapath.
// Depends on sia_pkg, sia_if, sia_ctrl, sia_dp (and sia_ram below it).
//
//   channel | dir | payload             | handshake
//   in_ch   | in  | value, base         | valid/ready
//   out_ch  | out | ascii_code, last_char | valid/ready
//
// One item at a time. Each digit comes from the single bit-serial divider and
// goes onto the digit stack RAM; each character is then read back (fetch,
// then emit) from that stack, the sign first if the value is negative.
// Synchronous active-low reset clears the sequencer and output valid.
// A stalled out_ch holds the character; the next number is taken while the
// last character still waits.
module signed_integer_to_ascii_base_core #(
  parameter int VALUE_WIDTH = sia_pkg::VALUE_WIDTH
) (
  input  logic      clk,
  input  logic      rst_n,
  sia_in_if.sink    in_ch,
  sia_out_if.source out_ch
);

  sia_pkg::cmd_t cmd;
  sia_pkg::sts_t sts;

  sia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sia_dp #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_ch.value),
    .in_base        (in_ch.base),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_ascii_code (out_ch.ascii_code),
    .out_last_char  (out_ch.last_char)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a conversion is in progress");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sign_out || cmd.digit_out) |-> sts.slot_free)
    else $error("character overwrites a word not yet taken");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.digit, cmd.sign_out, cmd.fetch, cmd.digit_out}))
    else $error("datapath commands overlap");

  a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.digit_out && sts.ndig_zero) |=> in_ch.ready)
    else $error("sequencer not idle after final character");
`endif

endmodule
